// ----- src/pca_pkg.sv -----
// shared types, constants and the control program of the pi controller
`timescale 1ns / 1ps

package pca_pkg;

	localparam int PC_W      = 4;
	localparam int CFG_IDX_W = 4;
	localparam int DRIVE_W   = 23;
	localparam int TERM_W    = 64;
	localparam int INC_W     = 48;

	localparam logic [31:0]        Q_ONE     = 32'd65536;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 23'd6553600;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_TIME = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd3;

	// program addresses
	localparam logic [PC_W-1:0] STEP_WAIT     = 4'd0;
	localparam logic [PC_W-1:0] STEP_MUL_P    = 4'd1;
	localparam logic [PC_W-1:0] STEP_MUL_P_LP = 4'd2;
	localparam logic [PC_W-1:0] STEP_PTERM    = 4'd3;
	localparam logic [PC_W-1:0] STEP_DIV_LP   = 4'd4;
	localparam logic [PC_W-1:0] STEP_ITERM    = 4'd5;
	localparam logic [PC_W-1:0] STEP_MUL_I_LP = 4'd6;
	localparam logic [PC_W-1:0] STEP_DRIVE    = 4'd7;
	localparam logic [PC_W-1:0] STEP_EMIT     = 4'd8;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_MUL_P,
		OP_MUL_STEP,
		OP_PTERM,
		OP_DIV_STEP,
		OP_ITERM,
		OP_DRIVE,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_CNT_NZ
	} cond_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_LOAD_MUL,
		CNT_LOAD_DIV,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		op_t             op;
		cnt_op_t         cnt_op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic en;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} stat_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_WAIT, cnt_op: CNT_HOLD, cond: COND_ALWAYS, target: STEP_WAIT};
		case (pc)
			STEP_WAIT:     w = '{OP_WAIT,      CNT_HOLD,     COND_NEXT,   STEP_WAIT};
			STEP_MUL_P:    w = '{OP_MUL_P,     CNT_LOAD_MUL, COND_NEXT,   STEP_WAIT};
			STEP_MUL_P_LP: w = '{OP_MUL_STEP,  CNT_DEC,      COND_CNT_NZ, STEP_MUL_P_LP};
			STEP_PTERM:    w = '{OP_PTERM,     CNT_LOAD_DIV, COND_NEXT,   STEP_WAIT};
			STEP_DIV_LP:   w = '{OP_DIV_STEP,  CNT_DEC,      COND_CNT_NZ, STEP_DIV_LP};
			STEP_ITERM:    w = '{OP_ITERM,     CNT_LOAD_MUL, COND_NEXT,   STEP_WAIT};
			STEP_MUL_I_LP: w = '{OP_MUL_STEP,  CNT_DEC,      COND_CNT_NZ, STEP_MUL_I_LP};
			STEP_DRIVE:    w = '{OP_DRIVE,     CNT_HOLD,     COND_NEXT,   STEP_WAIT};
			STEP_EMIT:     w = '{OP_EMIT,      CNT_HOLD,     COND_ALWAYS, STEP_WAIT};
			default:       w = '{OP_WAIT,      CNT_HOLD,     COND_ALWAYS, STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ----- src/pca_useq.sv -----
// step counter, loop counter and program lookup
`timescale 1ns / 1ps

module pca_useq #(
	parameter int MUL_STEPS = 33,
	parameter int DIV_STEPS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pca_pkg::stat_t  stat,
	output pca_pkg::ctrl_t  ctrl
);

	localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
	localparam int CW        = $clog2(MAX_STEPS);

	logic [pca_pkg::PC_W-1:0] pc_q;
	logic [CW-1:0]            cnt_q;
	pca_pkg::uword_t          uw;
	logic                     stall;

	always_comb begin
		uw = pca_pkg::ucode(pc_q);
		// wait for a beat at the wait step, hold the result step while the output is full
		stall = ((uw.op == pca_pkg::OP_WAIT) && !stat.in_valid) ||
		        ((uw.op == pca_pkg::OP_EMIT) && stat.out_busy);
		ctrl.en = !stall;
		ctrl.op = uw.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= pca_pkg::STEP_WAIT;
			cnt_q <= '0;
		end else if (ctrl.en) begin
			case (uw.cnt_op)
				pca_pkg::CNT_LOAD_MUL: cnt_q <= CW'(MUL_STEPS - 1);
				pca_pkg::CNT_LOAD_DIV: cnt_q <= CW'(DIV_STEPS - 1);
				pca_pkg::CNT_DEC:      cnt_q <= cnt_q - 1'b1;
				default:               cnt_q <= cnt_q;
			endcase
			case (uw.cond)
				pca_pkg::COND_ALWAYS: pc_q <= uw.target;
				pca_pkg::COND_CNT_NZ: pc_q <= (cnt_q != '0) ? uw.target : pc_q + 1'b1;
				default:              pc_q <= pc_q + 1'b1;
			endcase
		end
	end

endmodule

// ----- src/pca_datapath.sv -----
// shift-add multiplier, restoring divider and accumulator of the pi controller
`timescale 1ns / 1ps

module pca_datapath #(
	parameter int DATA_WIDTH = 32,
	parameter int ACC_WIDTH  = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pca_pkg::ctrl_t                ctrl,
	input  logic [DATA_WIDTH-1:0]         setpoint,
	input  logic [DATA_WIDTH-1:0]         proportional_gain,
	input  logic [30:0]                   integral_time,
	input  logic [30:0]                   sample_period,
	input  logic [DATA_WIDTH-1:0]         measured_value,
	output logic [pca_pkg::DRIVE_W-1:0]   res_drive,
	output logic                          res_limit
);

	localparam int DW = DATA_WIDTH;
	localparam int AW = ACC_WIDTH;
	localparam int EW = DW + 1;
	localparam int MB = (EW > 31) ? EW : 31;
	localparam int PW = EW + MB;
	localparam int XW = (PW > 64) ? PW : 64;
	localparam int DN = AW + 16;
	localparam int SW = 66;
	localparam int TW = pca_pkg::TERM_W;
	localparam int IW = pca_pkg::INC_W;

	localparam logic [XW-1:0] BIG = {{(XW-63){1'b0}}, 1'b1, 62'd0};

	logic [DW:0]          err_q;
	logic [EW-1:0]        mc_q;
	logic [MB-1:0]        mr_q;
	logic [PW-1:0]        prod_q;
	logic                 neg_q;
	logic [31:0]          rem_q;
	logic [DN-1:0]        quo_q;
	logic signed [TW-1:0] pterm_q;
	logic signed [TW-1:0] iterm_q;
	logic signed [TW-1:0] drive_q;
	logic signed [IW-1:0] inc_q;
	logic signed [AW-1:0] es_q;

	logic [EW-1:0]        err_next;
	logic [EW-1:0]        err_mag;
	logic [DW-1:0]        gain_mag;
	logic [AW-1:0]        es_mag;
	logic [XW-1:0]        prod_x;
	logic [62:0]          sat_mag;
	logic [TW-1:0]        tmag;
	logic [TW-1:0]        prod_term;
	logic [30:0]          ti_eff;
	logic [31:0]          sh;
	logic [32:0]          diff;
	logic [63:0]          qpart;
	logic [46:0]          qclamp;
	logic [TW-1:0]        imag;
	logic [TW-1:0]        iterm_val;
	logic signed [TW-1:0] drive_lim;
	logic                 in_band;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] hi;
	logic signed [SW-1:0] lo;
	logic [AW-1:0]        es_next;

	always_comb begin
		err_next = {setpoint[DW-1], setpoint} - {measured_value[DW-1], measured_value};
		err_mag  = err_q[DW] ? (EW'(0) - err_q) : err_q;
		gain_mag = proportional_gain[DW-1] ? (DW'(0) - proportional_gain) : proportional_gain;
		es_mag   = es_q[AW-1] ? (AW'(0) - es_q) : es_q;

		// product magnitude saturates at 2^62, then drops the fraction
		prod_x    = XW'(prod_q);
		sat_mag   = (prod_x > BIG) ? {1'b1, 62'd0} : prod_x[62:0];
		tmag      = {17'd0, sat_mag[62:16]};
		prod_term = neg_q ? (TW'(0) - tmag) : tmag;

		ti_eff = (integral_time == '0) ? 31'd1 : integral_time;
		sh     = {rem_q[30:0], quo_q[DN-1]};
		diff   = {1'b0, sh} - {2'b00, ti_eff};

		// integer part of the quotient limited to 2^46, fraction kept
		qpart     = 64'(quo_q[DN-1:16]);
		qclamp    = (qpart > (64'd1 << 46)) ? {1'b1, 46'd0} : qpart[46:0];
		imag      = {1'b0, qclamp, quo_q[15:0]};
		iterm_val = es_q[AW-1] ? (TW'(0) - imag) : imag;

		drive_lim = $signed({{(TW-pca_pkg::DRIVE_W){1'b0}}, pca_pkg::DRIVE_MAX});
		in_band   = (drive_q > 0) && (drive_q < drive_lim);
		res_limit = !in_band;
		if (in_band) begin
			res_drive = drive_q[pca_pkg::DRIVE_W-1:0];
		end else if (drive_q >= drive_lim) begin
			res_drive = pca_pkg::DRIVE_MAX;
		end else begin
			res_drive = '0;
		end

		sum = $signed({{(SW-AW){es_q[AW-1]}}, es_q}) + $signed({{(SW-IW){inc_q[IW-1]}}, inc_q});
		hi  = $signed({{(SW-AW+1){1'b0}}, {(AW-1){1'b1}}});
		lo  = $signed({{(SW-AW+1){1'b1}}, {(AW-1){1'b0}}});
		if (sum > hi) begin
			es_next = hi[AW-1:0];
		end else if (sum < lo) begin
			es_next = lo[AW-1:0];
		end else begin
			es_next = sum[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			es_q <= '0;
		end else if (ctrl.en && (ctrl.op == pca_pkg::OP_EMIT) && in_band) begin
			es_q <= es_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				pca_pkg::OP_WAIT: begin
					err_q <= err_next;
				end
				pca_pkg::OP_MUL_P: begin
					mc_q   <= EW'(gain_mag);
					mr_q   <= MB'(err_mag);
					prod_q <= '0;
					neg_q  <= proportional_gain[DW-1] ^ err_q[DW];
				end
				pca_pkg::OP_MUL_STEP: begin
					prod_q <= {prod_q[PW-2:0], 1'b0} + (mr_q[MB-1] ? PW'(mc_q) : PW'(0));
					mr_q   <= {mr_q[MB-2:0], 1'b0};
				end
				pca_pkg::OP_PTERM: begin
					pterm_q <= $signed(prod_term);
					rem_q   <= '0;
					quo_q   <= {es_mag, 16'd0};
				end
				pca_pkg::OP_DIV_STEP: begin
					if (!diff[32]) begin
						rem_q <= diff[31:0];
					end else begin
						rem_q <= sh;
					end
					quo_q <= {quo_q[DN-2:0], !diff[32]};
				end
				pca_pkg::OP_ITERM: begin
					iterm_q <= $signed(iterm_val);
					mc_q    <= err_mag;
					mr_q    <= MB'(sample_period);
					prod_q  <= '0;
					neg_q   <= err_q[DW];
				end
				pca_pkg::OP_DRIVE: begin
					drive_q <= pterm_q + iterm_q;
					inc_q   <= $signed(prod_term[IW-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/pi_controller_antiwindup.sv -----
// pi controller with conditional integration anti-windup, top level
// the sequencer takes a new sample only once the previous one has reached the output register;
//   the work is done by the bit-serial multiplier, used twice, and the one-bit-per-cycle divider
// reset: error sum cleared, setpoint 0, gain, integral time and sample period 1.0
`timescale 1ns / 1ps

module pi_controller_antiwindup #(
	parameter int DATA_WIDTH = 32,
	parameter int ACC_WIDTH  = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [DATA_WIDTH-1:0]             measured_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pca_pkg::DRIVE_W-1:0]       drive_value,
	output logic                              at_limit,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int MB = ((DW + 1) > 31) ? (DW + 1) : 31;
	localparam int DN = ACC_WIDTH + 16;

	logic [DW-1:0]                    setpoint_q;
	logic [DW-1:0]                    gain_q;
	logic [30:0]                      itime_q;
	logic [30:0]                      period_q;
	logic                             out_valid_q;
	logic [pca_pkg::DRIVE_W-1:0]      drive_q;
	logic                             limit_q;

	pca_pkg::ctrl_t                   ctrl;
	pca_pkg::stat_t                   stat;
	logic [pca_pkg::DRIVE_W-1:0]      res_drive;
	logic                             res_limit;
	logic                             emit;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (ctrl.op == pca_pkg::OP_WAIT);
	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign at_limit    = limit_q;
	assign emit        = ctrl.en && (ctrl.op == pca_pkg::OP_EMIT);

	always_comb begin
		stat.in_valid = in_valid;
		stat.out_busy = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			gain_q     <= DW'(pca_pkg::Q_ONE);
			itime_q    <= 31'(pca_pkg::Q_ONE);
			period_q   <= 31'(pca_pkg::Q_ONE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pca_pkg::REG_SETPOINT:      setpoint_q <= cfg_data[DW-1:0];
				pca_pkg::REG_GAIN:          gain_q     <= cfg_data[DW-1:0];
				pca_pkg::REG_INTEGRAL_TIME: itime_q    <= cfg_data[30:0];
				pca_pkg::REG_SAMPLE_PERIOD: period_q   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// output register: a finished beat waits here while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			drive_q <= res_drive;
			limit_q <= res_limit;
		end
	end

	pca_useq #(
		.MUL_STEPS (MB),
		.DIV_STEPS (DN)
	) u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	pca_datapath #(
		.DATA_WIDTH (DATA_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.setpoint          (setpoint_q),
		.proportional_gain (gain_q),
		.integral_time     (itime_q),
		.sample_period     (period_q),
		.measured_value    (measured_value),
		.res_drive         (res_drive),
		.res_limit         (res_limit)
	);

	// the sequencer leaves the wait step right after taking a beat
	a_leave_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_value <= pca_pkg::DRIVE_MAX)
		else $error("drive above upper bound");

	a_free_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !at_limit |-> (drive_value != '0) && (drive_value < pca_pkg::DRIVE_MAX))
		else $error("unlimited drive not strictly inside bounds");

	a_limit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_limit |-> (drive_value == '0) || (drive_value == pca_pkg::DRIVE_MAX))
		else $error("limited drive not at a bound");

endmodule

// ----- verif/pi_controller_antiwindup_check.sv -----
// result checker for the pi controller: tracks register writes, predicts each drive beat
`timescale 1ns / 1ps

module pi_controller_antiwindup_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [31:0]                       measured_value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [pca_pkg::DRIVE_W-1:0]       drive_value,
	input  logic                              at_limit,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [pca_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	output int                                mismatches,
	output int                                pending
);

	typedef struct packed {
		logic [pca_pkg::DRIVE_W-1:0] drive;
		logic                        at_limit;
	} drive_beat_t;

	localparam longint Q16         = 64'sd65536;
	localparam longint TERM_CAP    = 64'sd1 <<< 62;
	localparam longint QUOTIENT_CAP = 64'sd1 <<< 46;
	localparam longint SUM_MAX     = (64'sd1 <<< 47) - 64'sd1;
	localparam longint SUM_MIN     = -SUM_MAX - 64'sd1;
	localparam longint DRIVE_TOP   = 64'sd100 * Q16;

	longint setpoint_q;
	longint gain_q;
	longint integ_time_q;
	longint period_q;
	longint error_sum_q;

	drive_beat_t drive_expect[$];
	drive_beat_t oldest;

	// exact product, magnitude held to 2^62
	function automatic longint capped_product(input longint a, input longint b);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		wa = 128'(a);
		wb = 128'(b);
		p = wa * wb;
		if (p > TERM_CAP) return TERM_CAP;
		if (p < -TERM_CAP) return -TERM_CAP;
		return longint'(p);
	endfunction

	function automatic drive_beat_t control_step(input logic signed [31:0] sample);
		longint meas;
		longint err;
		longint pterm;
		longint divisor;
		longint quo;
		longint rem;
		longint iterm;
		longint drive;
		longint inc;
		drive_beat_t res;
		meas = longint'(sample);
		err = setpoint_q - meas;
		pterm = capped_product(gain_q, err) / Q16;
		divisor = (integ_time_q == 0) ? 64'sd1 : integ_time_q;
		quo = error_sum_q / divisor;
		rem = error_sum_q % divisor;
		if (quo > QUOTIENT_CAP) quo = QUOTIENT_CAP;
		else if (quo < -QUOTIENT_CAP) quo = -QUOTIENT_CAP;
		iterm = quo * Q16 + (rem * Q16) / divisor;
		drive = pterm + iterm;
		if (drive > 0 && drive < DRIVE_TOP) begin
			inc = capped_product(err, period_q) / Q16;
			if (inc > 0 && error_sum_q > SUM_MAX - inc) error_sum_q = SUM_MAX;
			else if (inc < 0 && error_sum_q < SUM_MIN - inc) error_sum_q = SUM_MIN;
			else error_sum_q = error_sum_q + inc;
			res.drive = pca_pkg::DRIVE_W'(drive);
			res.at_limit = 1'b0;
		end else begin
			// clamped or sitting on a bound: integration frozen
			res.drive = (drive >= DRIVE_TOP) ? pca_pkg::DRIVE_MAX : '0;
			res.at_limit = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q = 0;
			gain_q = Q16;
			integ_time_q = Q16;
			period_q = Q16;
			error_sum_q = 0;
			drive_expect.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_expect.size() == 0) begin
					$display("%0t unexpected beat: expected none, got drive %h at_limit %b",
						$time, drive_value, at_limit);
					mismatches++;
				end else begin
					oldest = drive_expect.pop_front();
					if (drive_value !== oldest.drive) begin
						$display("%0t drive_value: expected %h, got %h",
							$time, oldest.drive, drive_value);
						mismatches++;
					end
					if (at_limit !== oldest.at_limit) begin
						$display("%0t at_limit: expected %b, got %b",
							$time, oldest.at_limit, at_limit);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pca_pkg::REG_SETPOINT:      setpoint_q = longint'($signed(cfg_data));
					pca_pkg::REG_GAIN:          gain_q = longint'($signed(cfg_data));
					pca_pkg::REG_INTEGRAL_TIME: integ_time_q = longint'({33'd0, cfg_data[30:0]});
					pca_pkg::REG_SAMPLE_PERIOD: period_q = longint'({33'd0, cfg_data[30:0]});
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				drive_expect.push_back(control_step(measured_value));
			pending = drive_expect.size();
		end
	end

endmodule

// ----- verif/pi_controller_antiwindup_test.sv -----
// testbench top for the pi controller: stimulus, flow control and verdict
`timescale 1ns / 1ps

module pi_controller_antiwindup_test;

	localparam int SAMPLE_PHASES = 12;
	localparam int PHASE_SAMPLES = 150;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic [31:0]                   measured_value = '0;
	logic                          out_ready = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [pca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                   cfg_data = '0;
	logic                          in_ready;
	logic                          out_valid;
	logic                          cfg_ready;
	logic [pca_pkg::DRIVE_W-1:0]   drive_value;
	logic                          at_limit;

	int mismatches;
	int pending;
	int burst_left = 0;
	int drain_mode = 0;
	int mode_left = 0;
	int stall_left = 0;

	logic [31:0] phase_setpoint;
	int          phase_span;

	// bounds, exact-zero and exact-hundred drives at the reset settings
	logic [31:0] reset_points [11] = '{
		32'h0000_0000, 32'hFF9C_0000, 32'hFFCE_0000, 32'hFFCE_0000, 32'h0000_0000,
		32'h0032_0000, 32'h0018_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h0000_0001
	};

	pi_controller_antiwindup uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.measured_value (measured_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_value    (drive_value),
		.at_limit       (at_limit),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	pi_controller_antiwindup_check checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.measured_value (measured_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_value    (drive_value),
		.at_limit       (at_limit),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// result side: modes of steady, random, sparse and long-stall acceptance
	always @(negedge clk) begin
		if (mode_left == 0) begin
			drain_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(100, 800);
		end
		mode_left--;
		case (drain_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 7) == 0);
			default: begin
				if (stall_left == 0) begin
					out_ready <= 1'b1;
					stall_left = $urandom_range(0, 60);
				end else begin
					out_ready <= 1'b0;
					stall_left--;
				end
			end
		endcase
	end

	task automatic write_reg(input logic [pca_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic [31:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 180);
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		measured_value <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid and let every outstanding beat drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic program_phase(input int ph);
		logic [31:0] gain;
		logic [31:0] itime;
		logic [31:0] period;
		if (ph % 4 == 3) begin
			case ($urandom_range(0, 3))
				0: gain = $urandom();
				1: gain = 32'h7FFF_FFFF;
				2: gain = 32'h8000_0000;
				default: gain = '0;
			endcase
			phase_span = 50 * pca_pkg::Q_ONE;
		end else begin
			case ($urandom_range(0, 4))
				0: gain = 32'h0000_4000;
				1: gain = 32'h0000_8000;
				2: gain = pca_pkg::Q_ONE;
				3: gain = 32'h0002_0000;
				default: gain = 32'h0004_0000;
			endcase
			// error span that sweeps the drive across 0..100 and past both ends
			phase_span = int'((64'd50 << 32) / gain);
		end
		if (ph % 6 == 5)
			phase_setpoint = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		else
			phase_setpoint = ($urandom_range(0, 200) - 50) * pca_pkg::Q_ONE;
		case ($urandom_range(0, 5))
			0, 1: itime = pca_pkg::Q_ONE;
			2: itime = $urandom_range(1, 32'h0010_0000);
			3: itime = 32'h7FFF_FFFF;
			4: itime = '0;
			default: itime = 32'h0000_1000;
		endcase
		case ($urandom_range(0, 4))
			0, 1: period = pca_pkg::Q_ONE;
			2: period = '0;
			3: period = 32'h7FFF_FFFF;
			default: period = $urandom_range(0, 32'h0004_0000);
		endcase
		// top bit of the unsigned registers is dropped by the block
		itime[31] = 1'($urandom_range(0, 1));
		period[31] = 1'($urandom_range(0, 1));
		write_reg(pca_pkg::REG_SETPOINT, phase_setpoint);
		write_reg(pca_pkg::REG_GAIN, gain);
		write_reg(pca_pkg::REG_INTEGRAL_TIME, itime);
		write_reg(pca_pkg::REG_SAMPLE_PERIOD, period);
		write_reg(pca_pkg::CFG_IDX_W'($urandom_range(pca_pkg::REG_SAMPLE_PERIOD + 1,
			(1 << pca_pkg::CFG_IDX_W) - 1)), $urandom());
	endtask

	function automatic logic [31:0] next_measurement();
		int unsigned offset;
		if ($urandom_range(0, 99) < 15)
			return $urandom();
		offset = $urandom_range(0, 3 * phase_span);
		return phase_setpoint - offset + phase_span;
	endfunction

	initial begin
		int ph;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (reset_points[i])
			send_sample(reset_points[i]);
		settle();

		// zero integral time behaves as the smallest divisor
		write_reg(pca_pkg::REG_INTEGRAL_TIME, '0);
		send_sample(32'hFFFF_0000);
		settle();

		// products just below the term limit
		write_reg(pca_pkg::REG_INTEGRAL_TIME, pca_pkg::Q_ONE);
		write_reg(pca_pkg::REG_GAIN, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		settle();
		write_reg(pca_pkg::REG_GAIN, 32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		settle();

		// drive the error sum into its upper limit with the drive held just above zero,
		// then walk it back down near zero
		write_reg(pca_pkg::REG_SETPOINT, 32'h7FFF_FFFF);
		write_reg(pca_pkg::REG_GAIN, 32'h0000_0001);
		write_reg(pca_pkg::REG_INTEGRAL_TIME, 32'h4000_0000);
		write_reg(pca_pkg::REG_SAMPLE_PERIOD, 32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		settle();
		write_reg(pca_pkg::REG_GAIN, 32'hFFFF_0000);
		send_sample(32'h8000_0000);
		settle();
		write_reg(pca_pkg::REG_GAIN, 32'hFFFE_0000);
		send_sample(32'h8000_0000);
		settle();
		write_reg(pca_pkg::REG_SETPOINT, 32'h8000_0000);
		write_reg(pca_pkg::REG_GAIN, 32'h0002_0000);
		send_sample(32'h7FFF_FFFF);
		settle();
		write_reg(pca_pkg::REG_GAIN, 32'h0000_FFFF);
		send_sample(32'h7FFF_FFFF);
		settle();

		for (ph = 0; ph < SAMPLE_PHASES; ph++) begin
			program_phase(ph);
			repeat (PHASE_SAMPLES)
				send_sample(next_measurement());
			settle();
		end

		repeat (160) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/pca_pkg.sv
src/pca_useq.sv
src/pca_datapath.sv
src/pi_controller_antiwindup.sv
verif/pi_controller_antiwindup_check.sv
verif/pi_controller_antiwindup_test.sv
